### rtl/lms_pkg.sv
package lms_pkg;

  localparam int NUM_PLANES = 3;
  localparam int NUM_ROWS   = 8;
  localparam int NUM_WORDS  = NUM_PLANES * NUM_ROWS;
  localparam int WORD_W     = 16;
  localparam int FRAME_BITS = 64;
  localparam int IDX_W      = 6;
  localparam int NUM_LINES  = 6;

  // command codes
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_REDRAW = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // unused plane code for write row
  localparam logic [1:0] PLANE_NONE = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BITS - 1);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  red_col;
    logic [7:0]  green_col;
    logic [7:0]  blue_col;
    logic [1:0]  color_sel;
    logic [2:0]  row_sel;
    logic [15:0] row_value;
  } in_item_t;

  typedef struct packed {
    logic             red_upper;
    logic             red_lower;
    logic             green_upper;
    logic             green_lower;
    logic             blue_upper;
    logic             blue_lower;
    logic [IDX_W-1:0] shift_index;
    logic             latch;
  } out_item_t;

  // word index = plane * 8 + row
  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] frame_t;

  typedef struct packed {
    logic append;
    logic write;
    logic clear;
  } frame_ctl_t;

endpackage

### rtl/lms_frame.sv
module lms_frame (
  input  logic               clk,
  input  logic               rst,
  input  lms_pkg::frame_ctl_t ctl,
  input  lms_pkg::in_item_t  item,
  output lms_pkg::frame_t    frame
);
  import lms_pkg::*;

  logic [NUM_PLANES-1:0][7:0] cols;

  assign cols[0] = item.red_col;
  assign cols[1] = item.green_col;
  assign cols[2] = item.blue_col;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      frame <= '0;
    end else if (ctl.append) begin
      // every row shifts left, column bit r enters at bit 0 of row r
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int r = 0; r < NUM_ROWS; r++) begin
          frame[p*NUM_ROWS + r] <= {frame[p*NUM_ROWS + r][WORD_W-2:0], cols[p][r]};
        end
      end
    end else if (ctl.write && item.color_sel != PLANE_NONE) begin
      frame[{item.color_sel, item.row_sel}] <= item.row_value;
    end
  end

endmodule

### rtl/lms_bitsel.sv
module lms_bitsel (
  input  lms_pkg::frame_t                     frame,
  input  logic [lms_pkg::IDX_W-1:0]           idx,
  output logic [lms_pkg::NUM_LINES-1:0]       lines
);
  import lms_pkg::*;

  // idx[3:2] picks the row inside a half, {idx[5:4],idx[1:0]} counts
  // down from bit 15 of that row (nibble group high to low, MSB first)
  always_comb begin
    logic [4:0] widx;
    logic [3:0] bpos;
    bpos = ~{idx[5:4], idx[1:0]};
    lines = '0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int h = 0; h < 2; h++) begin
        widx = 5'(p*NUM_ROWS + h*4) | {3'b000, idx[3:2]};
        lines[p*2 + h] = frame[widx][bpos];
      end
    end
  end

endmodule

### rtl/lms_seq.sv
module lms_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [1:0]                cmd,
  output logic                      busy,
  output lms_pkg::frame_ctl_t       ctl,
  output logic                      active,
  output logic [lms_pkg::IDX_W-1:0] idx
);
  import lms_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_STREAM = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state == ST_STREAM);
  assign active = busy;
  assign accept = start && !busy;

  assign ctl.append = accept && (cmd == CMD_APPEND);
  assign ctl.write  = accept && (cmd == CMD_WRITE);
  assign ctl.clear  = accept && (cmd == CMD_CLEAR);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cmd != CMD_WRITE) state_next = ST_STREAM;
      end
      ST_STREAM: begin
        if (idx == LAST_IDX) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_STREAM) begin
        idx <= idx + IDX_W'(1);
      end else begin
        idx <= '0;
      end
    end
  end

endmodule

### rtl/led_matrix_scroll_serializer.sv
// Channel | Handshake         | Payload              | Notes
// --------+-------------------+----------------------+------------------------------
// in      | start, busy       | item   (in_item_t)   | taken when start && !busy
// out     | strobe            | result (out_item_t)  | one cycle per result, no stall
//
// Append, redraw and clear each stream the frame: any frame update lands
// at the accepting edge, then the bit counter walks 64 positions, one result
// per cycle out of the output register. busy drops in the cycle that shows
// the last (latch) result, so the next item may be taken then.
// Write row acts at the accepting edge and gives no result; busy stays low.
// Reset is synchronous and zeroes the frame and the sequencer.
// The receiver cannot hold results off; the block never waits on it.
module led_matrix_scroll_serializer (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  lms_pkg::in_item_t  item,
  output logic               strobe,
  output lms_pkg::out_item_t result
);
  import lms_pkg::*;

  frame_ctl_t             ctl;
  frame_t                 frame;
  logic                   active;
  logic [IDX_W-1:0]       idx;
  logic [NUM_LINES-1:0]   lines;

  // command decode and bit counter
  lms_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (item.cmd),
    .busy   (busy),
    .ctl    (ctl),
    .active (active),
    .idx    (idx)
  );

  // 24 x 16 frame; append/write/clear act at the accepting edge
  lms_frame u_frame (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .item  (item),
    .frame (frame)
  );

  // shared selector, reused every bit clock to pick the six data bits
  lms_bitsel u_bitsel (
    .frame (frame),
    .idx   (idx),
    .lines (lines)
  );

  // output register: strobe is control, payload is loaded without reset
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      result.red_upper   <= lines[0];
      result.red_lower   <= lines[1];
      result.green_upper <= lines[2];
      result.green_lower <= lines[3];
      result.blue_upper  <= lines[4];
      result.blue_lower  <= lines[5];
      result.shift_index <= idx;
      result.latch       <= (idx == LAST_IDX);
    end
  end

endmodule

### rtl/lms_checker.sv
module lms_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input lms_pkg::in_item_t  item,
  input logic               strobe,
  input lms_pkg::out_item_t result
);
  import lms_pkg::*;

  // a streaming command raises busy first, then shows bit 0 from the output register
  a_stream_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd != CMD_WRITE) |=> (busy && !strobe) ##1
      (strobe && result.shift_index == '0))
    else $error("stream did not start at bit 0");

  // bits within a frame are back to back and in order
  a_stream_order: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.latch) |=>
      (strobe && result.shift_index == $past(result.shift_index) + IDX_W'(1)))
    else $error("result sequence broken");

  // the block stays busy until the final bit is on the ports
  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.latch) |-> busy)
    else $error("busy dropped mid frame");

  // write row gives no output
  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == CMD_WRITE) |=> (!busy && !strobe))
    else $error("write row produced activity");

endmodule

bind led_matrix_scroll_serializer lms_checker u_lms_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .strobe (strobe),
  .result (result)
);
